// File: src/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int MAP_BYTES   = 1024;
  localparam int BLOCK_SH    = 9;   // 512-byte blocks
  localparam int PAGE_SH     = 12;  // 4096-byte pages
  localparam int BYTE_SH     = 3;   // eight blocks per map byte
  localparam int ADDR_W      = 23;
  localparam int PAGE_ADDR_W = 22;
  localparam int EXT_W       = 32;
  localparam int MAP_AW      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int NEED_W      = ADDR_W - PAGE_SH + 1;
  localparam int CNT_W       = (NEED_W > $clog2(MAP_BYTES + 1)) ? NEED_W
                                                                 : $clog2(MAP_BYTES + 1);
  localparam int BLK_LIM     = MAP_BYTES * 8 - 1;

  localparam logic [MAP_AW-1:0] LAST_BYTE     = MAP_AW'(MAP_BYTES - 1);
  localparam logic [ADDR_W-1:0] MEM_BYTES_RST = ADDR_W'(4194304);
  localparam logic [7:0]        FREE_BYTE     = 8'h00;
  localparam logic [7:0]        FULL_BYTE     = 8'hFF;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK
  } state_e;

  typedef struct packed {
    logic              empty;
    logic [MAP_AW-1:0] first_byte;
    logic [MAP_AW-1:0] last_byte;
    logic [2:0]        first_bit;
    logic [2:0]        last_bit;
  } range_t;

  typedef struct packed {
    logic                   status;
    logic [PAGE_ADDR_W-1:0] page_addr;
  } res_t;

endpackage

// File: src/bba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/bba_range.sv
// Converts a byte address region into first/last map byte and bit positions.
module bba_range (
  input  logic [bba_pkg::EXT_W-1:0] from_i,
  input  logic [bba_pkg::EXT_W-1:0] to_i,
  output bba_pkg::range_t           rng_o
);

  logic [bba_pkg::EXT_W-1:0] first_blk;
  logic [bba_pkg::EXT_W-1:0] last_raw;
  logic [bba_pkg::EXT_W-1:0] last_blk;

  always_comb begin
    first_blk = from_i >> bba_pkg::BLOCK_SH;
    // end block rounds up to the next block boundary, then clips to the map
    last_raw  = (to_i >> bba_pkg::BLOCK_SH)
              + bba_pkg::EXT_W'(|to_i[bba_pkg::BLOCK_SH-1:0]);
    last_blk  = (last_raw > bba_pkg::EXT_W'(bba_pkg::BLK_LIM))
              ? bba_pkg::EXT_W'(bba_pkg::BLK_LIM) : last_raw;

    rng_o.empty      = first_blk > last_blk;
    rng_o.first_byte = first_blk[bba_pkg::MAP_AW+bba_pkg::BYTE_SH-1:bba_pkg::BYTE_SH];
    rng_o.last_byte  = last_blk[bba_pkg::MAP_AW+bba_pkg::BYTE_SH-1:bba_pkg::BYTE_SH];
    rng_o.first_bit  = first_blk[bba_pkg::BYTE_SH-1:0];
    rng_o.last_bit   = last_blk[bba_pkg::BYTE_SH-1:0];
  end

endmodule

// File: src/bba_engine.sv
// Command sequencer: map clearing, first-fit scan and read-modify-write marking.
module bba_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [bba_pkg::ADDR_W-1:0]       from_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]       to_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]       req_size_i,
  input  logic [bba_pkg::ADDR_W-1:0]       memory_bytes_i,
  input  logic                             slot_free_i,
  output logic                             done_o,
  output bba_pkg::res_t                    res_o
);

  bba_pkg::state_e state_q, state_d;
  bba_pkg::cmd_e   cmd;
  bba_pkg::range_t rng_q, rng_d, rng_w;

  logic [bba_pkg::MAP_AW-1:0]      ptr_q, ptr_d, ptr_inc, paddr_q;
  logic                            pend_q, pend_d;
  logic                            set_q, set_d;
  logic [bba_pkg::CNT_W-1:0]       need_q, need_d, len_q, len_d, len_n;
  logic [bba_pkg::MAP_AW:0]        start_q, start_d, start_n;
  logic [bba_pkg::ADDR_W-1:0]      size_q, size_d;
  logic [bba_pkg::PAGE_ADDR_W-1:0] addr_q, addr_d;

  logic                       ram_we, ram_re;
  logic [bba_pkg::MAP_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata, mask;
  logic [2:0]                 lo_bit, hi_bit;

  logic [bba_pkg::EXT_W-1:0] mem_ext, base, alloc_end, rng_from, rng_to;
  logic in_fire, is_region, reg_ok, zero, hit, lim_ok, fit, beyond;
  logic scan_act, scan_hit, scan_fail, mark_end, clear_end;
  logic acc_scan, acc_mark, acc_done;

  assign cmd        = bba_pkg::cmd_e'(cmd_i);
  assign in_ready_o = (state_q == bba_pkg::ST_IDLE) && slot_free_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign mem_ext    = bba_pkg::EXT_W'(memory_bytes_i);
  assign ptr_inc    = (ptr_q == bba_pkg::LAST_BYTE) ? ptr_q : ptr_q + 1'b1;

  // region decode: command addresses when idle, allocated region otherwise
  assign base      = bba_pkg::EXT_W'(start_q) << bba_pkg::PAGE_SH;
  assign alloc_end = base + bba_pkg::EXT_W'(size_q);
  assign rng_from  = (state_q == bba_pkg::ST_IDLE) ? bba_pkg::EXT_W'(from_addr_i) : base;
  assign rng_to    = (state_q == bba_pkg::ST_IDLE) ? bba_pkg::EXT_W'(to_addr_i) : alloc_end;

  bba_range u_range (
    .from_i (rng_from),
    .to_i   (rng_to),
    .rng_o  (rng_w)
  );

  assign is_region = (cmd == bba_pkg::CMD_RESERVE) || (cmd == bba_pkg::CMD_FREE);
  assign reg_ok    = (to_addr_i <= memory_bytes_i)
                  && ((cmd != bba_pkg::CMD_FREE) || (to_addr_i != from_addr_i));
  assign acc_scan  = in_fire && (cmd == bba_pkg::CMD_ALLOC) && (req_size_i != '0);
  assign acc_mark  = in_fire && is_region && reg_ok && !rng_w.empty;
  assign acc_done  = in_fire && !acc_scan && !acc_mark;

  // first-fit scan: track the current run of free map bytes
  assign zero    = ram_rdata == bba_pkg::FREE_BYTE;
  assign len_n   = zero ? len_q + 1'b1 : '0;
  assign start_n = zero ? start_q : {1'b0, paddr_q} + 1'b1;
  assign hit     = zero && (len_n == need_q);
  assign lim_ok  = (start_q == '0) || (base <= mem_ext);
  assign fit     = alloc_end <= mem_ext;
  // a run restarting past the last candidate page can never qualify
  assign beyond  = (bba_pkg::EXT_W'(start_n) << bba_pkg::PAGE_SH) > mem_ext;

  assign scan_act  = (state_q == bba_pkg::ST_SCAN) && pend_q;
  assign scan_hit  = scan_act && hit && lim_ok && fit;
  assign scan_fail = scan_act && !scan_hit
                  && (hit || (!zero && beyond) || (paddr_q == bba_pkg::LAST_BYTE));
  assign mark_end  = (state_q == bba_pkg::ST_MARK) && pend_q
                  && (paddr_q == rng_q.last_byte);
  assign clear_end = (state_q == bba_pkg::ST_CLEAR) && (ptr_q == bba_pkg::LAST_BYTE);

  always_comb begin
    lo_bit = (paddr_q == rng_q.first_byte) ? rng_q.first_bit : 3'd0;
    hi_bit = (paddr_q == rng_q.last_byte) ? rng_q.last_bit : 3'd7;
    for (int b = 0; b < 8; b++) begin
      mask[b] = (3'(b) >= lo_bit) && (3'(b) <= hi_bit);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::ST_CLEAR: begin
        if (clear_end) state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (acc_scan) state_d = bba_pkg::ST_SCAN;
        else if (acc_mark) state_d = bba_pkg::ST_MARK;
      end
      bba_pkg::ST_SCAN: begin
        if (scan_hit) state_d = bba_pkg::ST_MARK;
        else if (scan_fail) state_d = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_MARK: begin
        if (mark_end) state_d = bba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    set_d     = set_q;
    rng_d     = rng_q;
    need_d    = need_q;
    len_d     = len_q;
    start_d   = start_q;
    size_d    = size_q;
    addr_d    = addr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = paddr_q;
    ram_raddr = ptr_q;
    ram_wdata = bba_pkg::FREE_BYTE;
    done_o    = 1'b0;
    res_o     = '0;
    unique case (state_q)
      bba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ptr_d     = clear_end ? '0 : ptr_inc;
      end
      bba_pkg::ST_IDLE: begin
        addr_d = '0;
        if (acc_scan) begin
          ptr_d   = '0;
          len_d   = '0;
          start_d = '0;
          need_d  = bba_pkg::CNT_W'(req_size_i >> bba_pkg::PAGE_SH) + 1'b1;
          size_d  = req_size_i;
        end else if (acc_mark) begin
          ptr_d = rng_w.first_byte;
          rng_d = rng_w;
          set_d = cmd == bba_pkg::CMD_RESERVE;
        end
        if (acc_done) begin
          done_o       = 1'b1;
          res_o.status = !(is_region && reg_ok);
        end
      end
      bba_pkg::ST_SCAN: begin
        ram_re = 1'b1;
        ptr_d  = ptr_inc;
        pend_d = !(scan_hit || scan_fail);
        if (pend_q) begin
          len_d   = len_n;
          start_d = start_n;
        end
        if (scan_hit) begin
          ptr_d  = rng_w.first_byte;
          rng_d  = rng_w;
          set_d  = 1'b1;
          addr_d = base[bba_pkg::PAGE_ADDR_W-1:0];
        end
        if (scan_fail) begin
          done_o       = 1'b1;
          res_o.status = 1'b1;
        end
      end
      bba_pkg::ST_MARK: begin
        // reads run one byte ahead of the write-back; addresses only rise
        ram_re    = 1'b1;
        ptr_d     = ptr_inc;
        pend_d    = !mark_end;
        ram_we    = pend_q;
        ram_wdata = set_q ? (ram_rdata | mask) : (ram_rdata & (bba_pkg::FULL_BYTE ^ mask));
        if (mark_end) begin
          done_o          = 1'b1;
          res_o.page_addr = addr_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::ST_CLEAR;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= ptr_q;
    set_q   <= set_d;
    rng_q   <= rng_d;
    need_q  <= need_d;
    len_q   <= len_d;
    start_q <= start_d;
    size_q  <= size_d;
    addr_q  <= addr_d;
  end

  bba_ram #(
    .WIDTH (8),
    .DEPTH (bba_pkg::MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bba_pkg::ST_CLEAR || state_q == bba_pkg::ST_MARK))
    else $error("map written outside clear or mark");

  a_mark_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_MARK && pend_q)
      |-> (paddr_q >= rng_q.first_byte && paddr_q <= rng_q.last_byte))
    else $error("write-back outside region");

  a_done_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> slot_free_i)
    else $error("result produced while output register is held");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == bba_pkg::ST_IDLE)
    else $error("sequencer not idle after result");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_CLEAR) |-> (!done_o && !in_ready_o))
    else $error("activity during map clear");

endmodule

// File: src/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: config register and result register.
//
// Keeps a used-bit map of 512-byte blocks (eight per map byte, one map byte per
// 4096-byte page) in a 1024 x 8 synchronous RAM. After reset the map is zeroed
// by a clearing pass (one map byte per cycle) during which no command is taken;
// memory_bytes writes are taken at any time. Commands that fail their checks,
// touch no block, or are unknown give their result in the cycle after
// acceptance. Reserve and free walk the touched map bytes with one
// read-modify-write per cycle, reads running one byte ahead of write-back.
// Allocate scans the map one byte a cycle up to the first free run of the
// needed length (stopping early when no candidate page is left), then marks
// the allocated blocks the same way.
module bitmap_block_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bba_pkg::ADDR_W-1:0]          memory_bytes_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [bba_pkg::ADDR_W-1:0]          from_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]          to_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]          req_size_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                status_o,
  output logic [bba_pkg::PAGE_ADDR_W-1:0]     page_addr_o
);

  logic [bba_pkg::ADDR_W-1:0] mem_bytes_q, mem_bytes_d;
  logic                       out_valid_q, out_valid_d;
  bba_pkg::res_t              res_q, res_d, res;
  logic                       done, slot_free;

  assign cfg_ready_o = 1'b1;
  assign mem_bytes_d = (cfg_valid_i && cfg_ready_o) ? memory_bytes_i : mem_bytes_q;

  // output register frees up in the same cycle its transaction completes
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = done || (out_valid_q && !out_ready_i);
  assign res_d       = done ? res : res_q;

  bba_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .from_addr_i    (from_addr_i),
    .to_addr_i      (to_addr_i),
    .req_size_i     (req_size_i),
    .memory_bytes_i (mem_bytes_q),
    .slot_free_i    (slot_free),
    .done_o         (done),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_bytes_q <= bba_pkg::MEM_BYTES_RST;
      out_valid_q <= 1'b0;
    end else begin
      mem_bytes_q <= mem_bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign page_addr_o = res_q.page_addr;

endmodule

// File: sim/alloc_checker.sv
// Checker for the bitmap block allocator: tracks the used-block map, predicts and compares.
module alloc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [bba_pkg::ADDR_W-1:0]      memory_bytes_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [1:0]                      cmd_i,
  input  logic [bba_pkg::ADDR_W-1:0]      from_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]      to_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]      req_size_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            status_i,
  input  logic [bba_pkg::PAGE_ADDR_W-1:0] page_addr_i,
  output int                              mismatches_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]                 block_map [bba_pkg::MAP_BYTES];
  logic [bba_pkg::ADDR_W-1:0] mem_limit;
  bba_pkg::res_t              expected_grants [$];
  bba_pkg::res_t              oldest;
  int                         mismatch_total;

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_total++;
  endtask

  // Blocks lo/512 .. ceil(hi/512), clipped to the map; backward ranges touch nothing.
  function automatic void mark_blocks(int unsigned lo, int unsigned hi, logic used);
    int unsigned first_blk;
    int unsigned last_blk;
    first_blk = lo >> bba_pkg::BLOCK_SH;
    last_blk  = (hi >> bba_pkg::BLOCK_SH) + (((hi % 512) != 0) ? 1 : 0);
    if (last_blk > bba_pkg::BLK_LIM) last_blk = bba_pkg::BLK_LIM;
    for (int unsigned b = first_blk; b <= last_blk; b++) begin
      block_map[b >> bba_pkg::BYTE_SH][b % 8] = used;
    end
  endfunction

  function automatic bit pages_free(int unsigned first_pg, int unsigned count);
    if (first_pg + count > bba_pkg::MAP_BYTES) return 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if (block_map[first_pg + k] != bba_pkg::FREE_BYTE) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bba_pkg::res_t predict_command(bba_pkg::cmd_e op,
                                                    logic [bba_pkg::ADDR_W-1:0] from_a,
                                                    logic [bba_pkg::ADDR_W-1:0] to_a,
                                                    logic [bba_pkg::ADDR_W-1:0] size);
    bba_pkg::res_t r;
    int unsigned   need;
    int unsigned   base;
    r.status    = 1'b1;
    r.page_addr = '0;
    case (op)
      bba_pkg::CMD_ALLOC: begin
        if (size != 0) begin
          need = (int'(size) >> bba_pkg::PAGE_SH) + 1;
          // first fit; only the first free run is considered even if it overruns memory
          for (int unsigned pg = 0; pg < bba_pkg::MAP_BYTES; pg++) begin
            if (pg != 0 && (pg << bba_pkg::PAGE_SH) > mem_limit) break;
            if (pages_free(pg, need)) begin
              base = pg << bba_pkg::PAGE_SH;
              if (base + size <= mem_limit) begin
                mark_blocks(base, base + size, 1'b1);
                r.status    = 1'b0;
                r.page_addr = base[bba_pkg::PAGE_ADDR_W-1:0];
              end
              break;
            end
          end
        end
      end
      bba_pkg::CMD_RESERVE: begin
        if (to_a <= mem_limit) begin
          mark_blocks(from_a, to_a, 1'b1);
          r.status = 1'b0;
        end
      end
      bba_pkg::CMD_FREE: begin
        if (to_a <= mem_limit && to_a != from_a) begin
          mark_blocks(from_a, to_a, 1'b0);
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (block_map[k]) block_map[k] = bba_pkg::FREE_BYTE;
      mem_limit = bba_pkg::MEM_BYTES_RST;
      expected_grants.delete();
      mismatch_total = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result", 0, {status_i, page_addr_i});
        end else begin
          oldest = expected_grants.pop_front();
          if (status_i !== oldest.status) begin
            report_mismatch("status", oldest.status, status_i);
          end
          if (page_addr_i !== oldest.page_addr) begin
            report_mismatch("page_addr", oldest.page_addr, page_addr_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mem_limit = memory_bytes_i;
      if (in_valid_i && in_ready_i) begin
        expected_grants.push_back(predict_command(bba_pkg::cmd_e'(cmd_i), from_addr_i,
                                                  to_addr_i, req_size_i));
      end
      mismatches_o <= mismatch_total;
      pending_o    <= expected_grants.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top for the bitmap block allocator: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [bba_pkg::ADDR_W-1:0]      mem_bytes   = bba_pkg::MEM_BYTES_RST;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [1:0]                      cmd         = bba_pkg::CMD_ALLOC;
  logic [bba_pkg::ADDR_W-1:0]      from_addr   = '0;
  logic [bba_pkg::ADDR_W-1:0]      to_addr     = '0;
  logic [bba_pkg::ADDR_W-1:0]      req_size    = '0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic                            status;
  logic [bba_pkg::PAGE_ADDR_W-1:0] page_addr;

  int                              mismatches;
  int                              pending_results;
  int                              idle_cycles = 0;
  int unsigned                     burst_left  = 0;
  int unsigned                     stall_mode  = 0;
  int unsigned                     stall_left  = 0;
  logic [bba_pkg::ADDR_W-1:0]      mem_setting = bba_pkg::MEM_BYTES_RST;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  bitmap_block_allocator i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .memory_bytes_i (mem_bytes),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .from_addr_i    (from_addr),
    .to_addr_i      (to_addr),
    .req_size_i     (req_size),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .page_addr_o    (page_addr)
  );

  alloc_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .memory_bytes_i (mem_bytes),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .from_addr_i    (from_addr),
    .to_addr_i      (to_addr),
    .req_size_i     (req_size),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .page_addr_i    (page_addr),
    .mismatches_o   (mismatches),
    .pending_o      (pending_results)
  );

  // Result side stalls in modes of random length: always ready, coin flip, mostly, rarely.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(1) == 1);
      2:       out_ready <= ($urandom_range(7) != 0);
      default: out_ready <= ($urandom_range(15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(bba_pkg::cmd_e op, logic [bba_pkg::ADDR_W-1:0] f,
                              logic [bba_pkg::ADDR_W-1:0] t,
                              logic [bba_pkg::ADDR_W-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    cmd       <= op;
    from_addr <= f;
    to_addr   <= t;
    req_size  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Called right after a transaction; pending count is registered, hence the do-while.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_memory_bytes(logic [bba_pkg::ADDR_W-1:0] v);
    cfg_valid   <= 1'b1;
    mem_bytes   <= v;
    mem_setting = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned                pick;
    int unsigned                top_page;
    logic [bba_pkg::ADDR_W-1:0] f;
    logic [bba_pkg::ADDR_W-1:0] t;
    logic [bba_pkg::ADDR_W-1:0] s;
    bba_pkg::cmd_e              op;
    top_page = ((mem_setting >> bba_pkg::PAGE_SH) > bba_pkg::MAP_BYTES - 1)
             ? bba_pkg::MAP_BYTES - 1 : (mem_setting >> bba_pkg::PAGE_SH);
    f    = bba_pkg::ADDR_W'($urandom);
    t    = bba_pkg::ADDR_W'($urandom);
    s    = bba_pkg::ADDR_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      op = bba_pkg::CMD_ALLOC;
      case ($urandom_range(9))
        0:       ;
        1:       s = bba_pkg::ADDR_W'($urandom_range(bba_pkg::MEM_BYTES_RST));
        2:       s = '0;
        default: s = bba_pkg::ADDR_W'($urandom_range(1, 20000));
      endcase
    end else if (pick < 94) begin
      op = (pick < 72) ? bba_pkg::CMD_FREE : bba_pkg::CMD_RESERVE;
      case ($urandom_range(9))
        0: ;
        1: t = f;
        2: t = f - bba_pkg::ADDR_W'($urandom_range(1, 65536));
        3: begin
          f = bba_pkg::ADDR_W'($urandom_range(mem_setting));
          t = mem_setting;
        end
        4: begin
          f = '0;
          t = mem_setting;
        end
        default: begin
          // page-aligned start, sometimes nudged inside the first block
          f = bba_pkg::ADDR_W'(($urandom_range(top_page) << bba_pkg::PAGE_SH) +
                               (($urandom_range(3) == 0) ? $urandom_range(511) : 0));
          t = f + bba_pkg::ADDR_W'($urandom_range(1, 24000));
        end
      endcase
    end else begin
      op = bba_pkg::CMD_NOP;
    end
    send_request(op, f, t, s);
  endtask

  initial begin
    logic [bba_pkg::ADDR_W-1:0] setting;
    int unsigned                count;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin setting = bba_pkg::MEM_BYTES_RST; count = 180; end
        1: begin setting = bba_pkg::ADDR_W'(65536); count = 150; end
        2: begin setting = '0; count = 50; end
        3: begin
          setting = bba_pkg::ADDR_W'($urandom_range(4096, bba_pkg::MEM_BYTES_RST));
          count   = 170;
        end
        4: begin setting = bba_pkg::ADDR_W'($urandom_range(1, 40000)); count = 150; end
        default: begin setting = bba_pkg::MEM_BYTES_RST; count = 150; end
      endcase
      if (ph != 0) wait_for_results();
      write_memory_bytes(setting);

      if (ph == 0) begin
        send_request(bba_pkg::CMD_ALLOC, '0, '0, '0);                  // zero size
        send_request(bba_pkg::CMD_ALLOC, '1, '1, '1);                  // run longer than map
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::MEM_BYTES_RST); // needs 1025 pages
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(1));
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(4096));
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(4095));
        send_request(bba_pkg::CMD_RESERVE, '0, '0, '0);
        // clipped at map end
        send_request(bba_pkg::CMD_RESERVE, bba_pkg::ADDR_W'(4190000),
                     bba_pkg::MEM_BYTES_RST, '0);
        // end past memory
        send_request(bba_pkg::CMD_RESERVE, '0, bba_pkg::ADDR_W'(4194305), '0);
        // empty free
        send_request(bba_pkg::CMD_FREE, bba_pkg::ADDR_W'(4096), bba_pkg::ADDR_W'(4096), '0);
        // backward region
        send_request(bba_pkg::CMD_FREE, bba_pkg::ADDR_W'(8192), bba_pkg::ADDR_W'(4096), '0);
        send_request(bba_pkg::CMD_RESERVE, '1, '0, '0);                // backward region
        send_request(bba_pkg::CMD_NOP, '1, '1, '1);
        send_request(bba_pkg::CMD_FREE, '0, bba_pkg::MEM_BYTES_RST, '0);
        // whole map in one go
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(4190208));
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(1)); // nothing left
        send_request(bba_pkg::CMD_FREE, '0, bba_pkg::MEM_BYTES_RST, '0);
        send_request(bba_pkg::CMD_RESERVE, bba_pkg::ADDR_W'(4096),
                     bba_pkg::ADDR_W'(4190208), '0);
        // no two-page run
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(5000));
        send_request(bba_pkg::CMD_ALLOC, '0, '0, bba_pkg::ADDR_W'(100));
        send_request(bba_pkg::CMD_FREE, '0, bba_pkg::MEM_BYTES_RST, '0);
        wait_for_results();
      end else if (ph == 4) begin
        // first free page fits but the size runs past memory
        send_request(bba_pkg::CMD_RESERVE, '0, bba_pkg::ADDR_W'(1), '0);
        send_request(bba_pkg::CMD_ALLOC, '0, '0, setting);
      end

      for (int unsigned n = 0; n < count; n++) begin
        send_random_request();
        if ($urandom_range(59) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
